// ----- hdl/kev_pkg.sv -----
package kev_pkg;

   // key code seen when no key is pressed
   localparam logic [7:0] NO_KEY_CODE = 8'd0;

   // default spacing of repeating hold events
   localparam int HOLD_REPEAT_DEFAULT = 10;

   // register indexes on the csr port
   localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
   localparam logic [1:0] REG_HOLD_PRESS   = 2'd1;
   localparam logic [1:0] REG_CLICK_WINDOW = 2'd2;
   localparam logic [1:0] REG_DEBOUNCE     = 2'd3;

   // reset values of the registers
   localparam logic [15:0] LONG_PRESS_RESET   = 16'd50;
   localparam logic [15:0] HOLD_PRESS_RESET   = 16'd100;
   localparam logic [7:0]  CLICK_WINDOW_RESET = 8'd25;
   localparam logic [7:0]  DEBOUNCE_RESET     = 8'd3;

   // request function codes
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_CLICK  = 3'd1,
      EV_DOUBLE = 3'd2,
      EV_TRIPLE = 3'd3,
      EV_LONG   = 3'd4,
      EV_HOLD   = 3'd5,
      EV_UP     = 3'd6
   } event_kind_type;

   typedef struct packed {
      logic [15:0] long_press_ticks;
      logic [15:0] hold_press_ticks;
      logic [7:0]  click_window_ticks;
      logic [7:0]  debounce_ticks;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] key;
   } event_type;

endpackage

// ----- hdl/kev_core.sv -----
module kev_core #(
   parameter int HOLD_REPEAT = kev_pkg::HOLD_REPEAT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic               func,
   input  logic [7:0]         key_code,
   input  kev_pkg::cfg_type   cfg,
   output kev_pkg::event_type latched
);
   import kev_pkg::*;

   localparam int RW = (HOLD_REPEAT > 1) ? $clog2(HOLD_REPEAT) : 1;
   localparam logic [RW-1:0] RES_LAST = RW'(HOLD_REPEAT - 1);

   logic [7:0]    stable_key_ff, stable_key_in;
   logic [7:0]    debounce_count_ff, debounce_count_in;
   logic [15:0]   held_ticks_ff, held_ticks_in;
   logic [RW-1:0] held_res_ff, held_res_in;
   logic [7:0]    click_total_ff, click_total_in;
   logic [7:0]    waiting_key_ff, waiting_key_in;
   logic [7:0]    window_timer_ff, window_timer_in;
   logic [2:0]    latched_kind_ff, latched_kind_in;
   logic [7:0]    latched_key_ff, latched_key_in;

   // next state for one scan tick or one read
   always_comb begin
      stable_key_in     = stable_key_ff;
      debounce_count_in = debounce_count_ff;
      held_ticks_in     = held_ticks_ff;
      held_res_in       = held_res_ff;
      click_total_in    = click_total_ff;
      waiting_key_in    = waiting_key_ff;
      window_timer_in   = window_timer_ff;
      latched_kind_in   = latched_kind_ff;
      latched_key_in    = latched_key_ff;

      if (func == FUNC_READ) begin
         latched_kind_in = EV_NONE;
         latched_key_in  = NO_KEY_CODE;
      end else begin
         // debounce and press tracking
         if (key_code != stable_key_ff) begin
            debounce_count_in = debounce_count_ff + 8'd1;
            if (debounce_count_in >= cfg.debounce_ticks) begin
               if (key_code == NO_KEY_CODE) begin
                  if (held_ticks_ff >= cfg.long_press_ticks) begin
                     latched_kind_in = EV_UP;
                     latched_key_in  = waiting_key_ff;
                  end else begin
                     click_total_in  = click_total_ff + 8'd1;
                     waiting_key_in  = stable_key_ff;
                     window_timer_in = cfg.click_window_ticks;
                  end
                  held_ticks_in = '0;
                  held_res_in   = '0;
               end else begin
                  waiting_key_in = key_code;
               end
               stable_key_in = key_code;
            end
         end else begin
            debounce_count_in = '0;
            if (key_code != NO_KEY_CODE) begin
               held_ticks_in = held_ticks_ff + 16'd1;
               // residue of held_ticks modulo the hold spacing
               if (held_ticks_in == 16'd0 || held_res_ff == RES_LAST) begin
                  held_res_in = '0;
               end else begin
                  held_res_in = held_res_ff + RW'(1);
               end
               if (held_ticks_in == cfg.long_press_ticks) begin
                  click_total_in  = '0;
                  latched_kind_in = EV_LONG;
                  latched_key_in  = key_code;
               end else if (held_ticks_in >= cfg.hold_press_ticks &&
                            held_res_in == '0) begin
                  latched_kind_in = EV_HOLD;
                  latched_key_in  = key_code;
               end
            end
         end

         // click window countdown
         if (window_timer_in != 8'd0) begin
            window_timer_in = window_timer_in - 8'd1;
            if (window_timer_in == 8'd0) begin
               case (click_total_in)
                  8'd1:    latched_kind_in = EV_CLICK;
                  8'd2:    latched_kind_in = EV_DOUBLE;
                  8'd3:    latched_kind_in = EV_TRIPLE;
                  default: latched_kind_in = latched_kind_in;
               endcase
               latched_key_in = waiting_key_in;
               click_total_in = '0;
               waiting_key_in = NO_KEY_CODE;
            end
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_key_ff     <= NO_KEY_CODE;
         debounce_count_ff <= '0;
         held_ticks_ff     <= '0;
         held_res_ff       <= '0;
         click_total_ff    <= '0;
         waiting_key_ff    <= NO_KEY_CODE;
         window_timer_ff   <= '0;
         latched_kind_ff   <= EV_NONE;
         latched_key_ff    <= NO_KEY_CODE;
      end else if (fire) begin
         stable_key_ff     <= stable_key_in;
         debounce_count_ff <= debounce_count_in;
         held_ticks_ff     <= held_ticks_in;
         held_res_ff       <= held_res_in;
         click_total_ff    <= click_total_in;
         waiting_key_ff    <= waiting_key_in;
         window_timer_ff   <= window_timer_in;
         latched_kind_ff   <= latched_kind_in;
         latched_key_ff    <= latched_key_in;
      end
   end

   assign latched.kind = latched_kind_ff;
   assign latched.key  = latched_key_ff;

endmodule

// ----- hdl/key_event_detector.sv -----
// channel | ports                                   | direction
// req     | req_valid req_ready req_func req_key_code | in
// rsp     | rsp_valid rsp_ready rsp_event_kind rsp_event_key | out
// csr     | csr_write_enable csr_index csr_write_data | in
//
// a word is taken into an input register, processed from there and a read
// lands in the result register; one word per cycle while no read stalls
// reset clears all event state and loads the default timing registers
// a stalled result only holds back read words; scan words keep flowing until
// a read reaches the input register, so input ready follows rsp_ready then
module key_event_detector #(
   parameter int HOLD_REPEAT = kev_pkg::HOLD_REPEAT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_key_code,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [7:0]  rsp_event_key,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);
   import kev_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_func_ff;
   logic [7:0] in_key_ff;
   logic       out_valid_ff;
   logic [2:0] out_kind_ff;
   logic [7:0] out_key_ff;
   logic       proc_fire;
   event_type  latched;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks   <= LONG_PRESS_RESET;
         cfg_ff.hold_press_ticks   <= HOLD_PRESS_RESET;
         cfg_ff.click_window_ticks <= CLICK_WINDOW_RESET;
         cfg_ff.debounce_ticks     <= DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LONG_PRESS:   cfg_ff.long_press_ticks   <= csr_write_data;
            REG_HOLD_PRESS:   cfg_ff.hold_press_ticks   <= csr_write_data;
            REG_CLICK_WINDOW: cfg_ff.click_window_ticks <= csr_write_data[7:0];
            REG_DEBOUNCE:     cfg_ff.debounce_ticks     <= csr_write_data[7:0];
            default:          cfg_ff <= cfg_ff;
         endcase
      end
   end

   // a read needs room in the result register, a scan never waits
   assign proc_fire = in_valid_ff &&
                      (in_func_ff == FUNC_SCAN || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || proc_fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff <= req_func;
         in_key_ff  <= req_key_code;
      end
   end

   kev_core #(
      .HOLD_REPEAT(HOLD_REPEAT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (proc_fire),
      .func     (in_func_ff),
      .key_code (in_key_ff),
      .cfg      (cfg_ff),
      .latched  (latched)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire && in_func_ff == FUNC_READ) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (proc_fire && in_func_ff == FUNC_READ) begin
         out_kind_ff <= latched.kind;
         out_key_ff  <= latched.key;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_event_key  = out_key_ff;

endmodule

// ----- tb/key_event_checker.sv -----
`timescale 1ns / 1ps

module key_event_checker #(
   parameter int HOLD_REPEAT = kev_pkg::HOLD_REPEAT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_key_code,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_event_kind,
   input  logic [7:0]  rsp_event_key,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int          pending_count,
   output int          mismatch_count,
   output int          checked_count
);
   import kev_pkg::*;

   // timing registers as the block should hold them
   cfg_type cfg;

   // predicted detector state
   logic [7:0]  stable_key;
   logic [7:0]  bounce_count;
   logic [15:0] held_count;
   logic [7:0]  tap_total;
   logic [7:0]  click_key;
   logic [7:0]  window_left;
   event_type   latched;

   // event words owed to the result channel, oldest first
   event_type   expected_events[$];
   event_type   want;
   int          mismatches;
   int          checked;

   task automatic flag_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // one scan tick: debounce, press timing and click window
   task automatic scan_word(input logic [7:0] code);
      if (code != stable_key) begin
         bounce_count = bounce_count + 8'd1;
         if (bounce_count >= cfg.debounce_ticks) begin
            if (code == NO_KEY_CODE) begin
               if (held_count >= cfg.long_press_ticks) begin
                  // release after a long press reports the remembered key
                  latched.kind = EV_UP;
                  latched.key  = click_key;
               end else begin
                  tap_total   = tap_total + 8'd1;
                  click_key   = stable_key;
                  window_left = cfg.click_window_ticks;
               end
               held_count = '0;
            end else begin
               click_key = code;
            end
            stable_key = code;
         end
      end else begin
         bounce_count = '0;
         if (code != NO_KEY_CODE) begin
            held_count = held_count + 16'd1;
            if (held_count == cfg.long_press_ticks) begin
               tap_total    = '0;
               latched.kind = EV_LONG;
               latched.key  = code;
            end else if (held_count >= cfg.hold_press_ticks &&
                         (held_count % HOLD_REPEAT) == 0) begin
               latched.kind = EV_HOLD;
               latched.key  = code;
            end
         end
      end

      // click window countdown; more than three clicks keep the old kind
      if (window_left != 8'd0) begin
         window_left = window_left - 8'd1;
         if (window_left == 8'd0) begin
            case (tap_total)
               8'd1: latched.kind = EV_CLICK;
               8'd2: latched.kind = EV_DOUBLE;
               8'd3: latched.kind = EV_TRIPLE;
               default: ;
            endcase
            latched.key = click_key;
            tap_total   = '0;
            click_key   = NO_KEY_CODE;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.long_press_ticks   = LONG_PRESS_RESET;
         cfg.hold_press_ticks   = HOLD_PRESS_RESET;
         cfg.click_window_ticks = CLICK_WINDOW_RESET;
         cfg.debounce_ticks     = DEBOUNCE_RESET;
         stable_key   = NO_KEY_CODE;
         bounce_count = '0;
         held_count   = '0;
         tap_total    = '0;
         click_key    = NO_KEY_CODE;
         window_left  = '0;
         latched.kind = EV_NONE;
         latched.key  = NO_KEY_CODE;
         expected_events.delete();
         mismatches = 0;
         checked    = 0;
      end else begin
         // compare a delivered event word with the oldest one owed
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               flag_mismatch($sformatf("event word kind %0d key %0h with none owed",
                                       rsp_event_kind, rsp_event_key));
            end else begin
               want = expected_events.pop_front();
               checked++;
               if (rsp_event_kind !== want.kind)
                  flag_mismatch($sformatf("event %0d kind %0d, wanted %0d",
                                          checked, rsp_event_kind, want.kind));
               if (rsp_event_key !== want.key)
                  flag_mismatch($sformatf("event %0d key %0h, wanted %0h",
                                          checked, rsp_event_key, want.key));
            end
         end

         // register writes
         if (csr_write_enable) begin
            case (csr_index)
               REG_LONG_PRESS:   cfg.long_press_ticks   = csr_write_data;
               REG_HOLD_PRESS:   cfg.hold_press_ticks   = csr_write_data;
               REG_CLICK_WINDOW: cfg.click_window_ticks = csr_write_data[7:0];
               REG_DEBOUNCE:     cfg.debounce_ticks     = csr_write_data[7:0];
               default: ;
            endcase
         end

         // accepted request word
         if (req_valid && req_ready) begin
            if (req_func == FUNC_READ) begin
               expected_events.push_back(latched);
               latched.kind = EV_NONE;
               latched.key  = NO_KEY_CODE;
            end else begin
               scan_word(req_key_code);
            end
         end
      end
      pending_count  <= expected_events.size();
      mismatch_count <= mismatches;
      checked_count  <= checked;
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import kev_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_STALL    = 250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_func = FUNC_SCAN;
   logic [7:0]  req_key_code = NO_KEY_CODE;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_event_key;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = REG_LONG_PRESS;
   logic [15:0] csr_write_data = '0;

   int pending_count;
   int mismatch_count;
   int checked_count;

   // stimulus bookkeeping
   logic calm = 1'b0;
   int   stall_token = 0;
   int   stall_seen = 0;
   int   stall_left = 0;
   int   cycle_count = 0;
   int   words_sent = 0;
   int   reads_sent = 0;
   int   settings_used = 0;
   int   read_pct = 8;
   int   cur_long;
   int   cur_hold;
   int   cur_window;
   int   cur_debounce;
   int   phase_end;

   key_event_detector u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_key    (rsp_event_key),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   key_event_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_event_key    (rsp_event_key),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pending_count    (pending_count),
      .mismatch_count   (mismatch_count),
      .checked_count    (checked_count)
   );

   always #4 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result side: random back pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (stall_token != stall_seen) begin
         stall_seen = stall_token;
         stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   // offer one request word and wait for its handshake
   task automatic send_word(input logic func, input logic [7:0] code);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_key_code <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (func == FUNC_READ) reads_sent++;
   endtask

   // scan one code for a number of ticks, with random reads in between
   task automatic hold_code(input logic [7:0] code, input int ticks);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(99) < read_pct) send_word(FUNC_READ, 8'($urandom));
         send_word(FUNC_SCAN, code);
      end
   endtask

   // stop offering and wait until every owed event word has arrived
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
   endtask

   // load all four timing registers while the block is idle
   task automatic apply_timing(input int long_ticks, input int hold_ticks,
                               input int window_ticks, input int bounce_ticks);
      settle();
      csr_write(REG_LONG_PRESS, 16'(long_ticks));
      csr_write(REG_HOLD_PRESS, 16'(hold_ticks));
      csr_write(REG_CLICK_WINDOW, 16'(window_ticks));
      csr_write(REG_DEBOUNCE, 16'(bounce_ticks));
      csr_write_enable <= 1'b0;
      cur_long     = long_ticks;
      cur_hold     = hold_ticks;
      cur_window   = window_ticks;
      cur_debounce = bounce_ticks;
      settings_used++;
   endtask

   // one user gesture with random content, scaled to the current timing
   task automatic gesture();
      logic [7:0] key;
      int         pick;
      int         taps;
      int         extra;
      key  = 8'($urandom_range(1, 255));
      pick = $urandom_range(99);
      if (pick < 45) begin
         // burst of short taps, some with contact bounce
         taps = $urandom_range(1, 4);
         repeat (taps) begin
            if ($urandom_range(99) < 30) begin
               hold_code(key, $urandom_range(0, cur_debounce));
               hold_code(NO_KEY_CODE, 1);
            end
            hold_code(key, cur_debounce + $urandom_range(0, cur_long / 2 + 1));
            hold_code(NO_KEY_CODE, cur_debounce + $urandom_range(0, cur_window / 2 + 1));
         end
         hold_code(NO_KEY_CODE, cur_window + $urandom_range(0, 4));
      end else if (pick < 75) begin
         // long press running into the hold repeats
         extra = (cur_hold > cur_long) ? cur_hold - cur_long + 30 : 30;
         hold_code(key, cur_debounce + cur_long + $urandom_range(0, extra));
         hold_code(NO_KEY_CODE, cur_debounce + $urandom_range(0, cur_window + 3));
      end else if (pick < 88) begin
         // change from one key straight to another
         hold_code(key, cur_debounce + $urandom_range(0, cur_long));
         hold_code(8'($urandom_range(1, 255)), cur_debounce + $urandom_range(0, cur_long + 10));
         hold_code(NO_KEY_CODE, cur_debounce + $urandom_range(0, cur_window + 3));
      end else begin
         // noise words
         repeat ($urandom_range(3, 20)) send_word(1'($urandom), 8'($urandom));
      end
      send_word(FUNC_READ, 8'($urandom));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty latch, click, long press, hold, key change, up
      apply_timing(4, 6, 3, 1);
      read_pct = 0;
      send_word(FUNC_READ, 8'hFF);
      hold_code(8'hFF, 2);
      hold_code(NO_KEY_CODE, 3);
      send_word(FUNC_READ, 8'h00);
      hold_code(8'h01, 12);
      send_word(FUNC_READ, 8'h5A);
      hold_code(8'h80, 1);
      hold_code(NO_KEY_CODE, 1);
      send_word(FUNC_READ, 8'hA5);
      read_pct = 8;

      // all timing at zero: no debounce, no click window
      apply_timing(0, 0, 0, 0);
      repeat (6) gesture();

      // click window of one tick
      apply_timing(10, 20, 1, 1);
      repeat (8) gesture();

      // random timing settings
      for (int p = 0; p < 7; p++) begin
         apply_timing($urandom_range(5, 40), 0, $urandom_range(0, 20),
                      ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5));
         if ($urandom_range(0, 3) == 0) cur_hold = $urandom_range(0, cur_long);
         else cur_hold = cur_long + $urandom_range(0, 40);
         apply_timing(cur_long, cur_hold, cur_window, cur_debounce);
         if (p == 2) begin
            // result side holds off while words keep coming
            stall_token <= stall_token + 1;
            repeat (40) send_word(1'($urandom_range(0, 3) == 0), 8'($urandom));
            // pause until every owed word is back
            settle();
            // stretch with no idling on either side
            calm <= 1'b1;
            phase_end = words_sent + 120;
            while (words_sent < phase_end) gesture();
            calm <= 1'b0;
         end
         phase_end = words_sent + 60;
         while (words_sent < phase_end) gesture();
      end

      // widest timing: slowest debounce with the longest press and window
      apply_timing(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      read_pct = 2;
      hold_code(8'hFF, 258);
      hold_code(NO_KEY_CODE, 258);
      send_word(FUNC_READ, 8'h00);

      settle();
      $display("covered %0d words (%0d reads) over %0d timing settings",
               words_sent, reads_sent, settings_used);
      $display("compared %0d event words, with zero, narrow, random and widest timing",
               checked_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
